// ===== rtl/rspd_pkg.sv =====
// Shared types, constants and helper functions of the rsyncable sync point detector.
`timescale 1ns / 1ps

package rspd_pkg;

	// The window length must be a power of two: a match tests the low bits of the sum.
	localparam int WINDOW_SIZE = 4096;
	localparam int WIN_AW      = $clog2(WINDOW_SIZE);
	localparam int SUM_W       = $clog2(WINDOW_SIZE * 255 + 1);

	localparam int MAGIC_LEN = 6;
	localparam int HDR_LEN   = 110;
	localparam int MODE_AT   = 14;
	localparam int NLNK_AT   = 38;
	localparam int SIZE_AT   = 54;
	localparam int FIELD_LEN = 8;
	localparam int POS_W     = 7;

	localparam logic [31:0] MODE_TYPE_MASK = 32'h0000_F000;
	localparam logic [31:0] MODE_REGULAR   = 32'h0000_8000;

	localparam logic [31:0] FORCE_PENDING_RST = 32'd8192;
	localparam logic [31:0] MIN_FILE_SIZE_RST = 32'd4096;
	localparam logic [31:0] MIN_PENDING_RST   = 32'd2048;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_FORCE_PENDING = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_FILE_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PENDING   = 2'd2;

	typedef enum logic [1:0] {
		CAUSE_NONE   = 2'd0,
		CAUSE_HEADER = 2'd1,
		CAUSE_ROLL   = 2'd2
	} cause_e;

	typedef struct packed {
		logic [31:0] force_pending;
		logic [31:0] min_file_size;
		logic [31:0] min_pending;
	} cfg_t;

	typedef struct packed {
		logic hdr_end;
		logic size_ok;
	} hdr_info_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] nibble;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] b);
		hex_t h;
		h = '0;
		if (b >= 8'h30 && b <= 8'h39) begin
			h.valid  = 1'b1;
			h.nibble = 4'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			h.valid  = 1'b1;
			h.nibble = 4'(b - 8'h57);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			h.valid  = 1'b1;
			h.nibble = 4'(b - 8'h37);
		end
		return h;
	endfunction

	function automatic logic [7:0] magic_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = 8'h30;
			3'd1: c = 8'h37;
			3'd2: c = 8'h30;
			3'd3: c = 8'h37;
			3'd4: c = 8'h30;
			3'd5: c = 8'h31;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/rspd_if.sv =====
// Valid/ready channel interfaces for the byte stream, the results and configuration writes.
`timescale 1ns / 1ps

interface rspd_byte_if import rspd_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface rspd_res_if import rspd_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       sync;
	logic [1:0] sync_cause;

	modport source (output valid, output sync, output sync_cause, input ready);
	modport sink (input valid, input sync, input sync_cause, output ready);
endinterface

interface rspd_cfg_if import rspd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/rspd_hdr.sv =====
// cpio newc header tracker: magic match, hex field gathering and header end detection.
`timescale 1ns / 1ps

module rspd_hdr import rspd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic [7:0] data_byte,
	input  cfg_t      cfg,
	output hdr_info_t info
);

	logic [POS_W-1:0] pos_q, pos_n;
	logic [31:0]      mode_q, mode_n;
	logic [31:0]      nlnk_q, nlnk_n;
	logic [31:0]      fsize_q, fsize_n;
	hex_t             hex;

	always_comb begin
		hex     = hex_decode(data_byte);
		pos_n   = pos_q;
		mode_n  = mode_q;
		nlnk_n  = nlnk_q;
		fsize_n = fsize_q;
		info    = '0;
		if (pos_q < POS_W'(MAGIC_LEN)) begin
			if (data_byte == magic_char(pos_q[2:0])) begin
				pos_n = pos_q + 1'b1;
			end else begin
				pos_n = '0;
			end
		end else if (!hex.valid) begin
			pos_n = '0;
		end else begin
			if (pos_q >= POS_W'(MODE_AT) && pos_q < POS_W'(MODE_AT + FIELD_LEN)) begin
				mode_n = (pos_q == POS_W'(MODE_AT)) ? {28'd0, hex.nibble}
					: {mode_q[27:0], hex.nibble};
			end else if (pos_q >= POS_W'(NLNK_AT) && pos_q < POS_W'(NLNK_AT + FIELD_LEN)) begin
				nlnk_n = (pos_q == POS_W'(NLNK_AT)) ? {28'd0, hex.nibble}
					: {nlnk_q[27:0], hex.nibble};
			end else if (pos_q >= POS_W'(SIZE_AT) && pos_q < POS_W'(SIZE_AT + FIELD_LEN)) begin
				fsize_n = (pos_q == POS_W'(SIZE_AT)) ? {28'd0, hex.nibble}
					: {fsize_q[27:0], hex.nibble};
			end
			if (pos_q == POS_W'(HDR_LEN - 1)) begin
				pos_n        = '0;
				info.hdr_end = 1'b1;
				if ((mode_n & MODE_TYPE_MASK) != MODE_REGULAR || nlnk_n != 32'd1) begin
					fsize_n = '0;
				end
				info.size_ok = (fsize_n >= cfg.min_file_size);
			end else begin
				pos_n = pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			mode_q  <= '0;
			nlnk_q  <= '0;
			fsize_q <= '0;
		end else if (en) begin
			pos_q   <= pos_n;
			mode_q  <= mode_n;
			nlnk_q  <= nlnk_n;
			fsize_q <= fsize_n;
		end
	end

endmodule

// ===== rtl/rspd_win.sv =====
// Rolling window memory with its sum, index and fill state, and the pending byte counter.
`timescale 1ns / 1ps

module rspd_win import rspd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      rd_en,
	input  logic      fire_s1,
	input  logic [7:0] byte_s1,
	input  hdr_info_t info_s1,
	input  cfg_t      cfg,
	output logic      sync,
	output cause_e    cause
);

	logic [7:0]        mem [WINDOW_SIZE];
	logic [7:0]        rdata_q;
	logic [WIN_AW-1:0] idx_q, idx_n, idx_inc, rd_addr;
	logic              full_q, full_n;
	logic [SUM_W-1:0]  sum_q, sum_n, roll_sum;
	logic [31:0]       pend_q, pend_n, pend_inc;
	logic              step;
	logic              idx_last;

	always_comb begin
		step     = !info_s1.hdr_end;
		idx_last = (idx_q == WIN_AW'(WINDOW_SIZE - 1));
		idx_inc  = idx_last ? '0 : idx_q + 1'b1;
		rd_addr  = (fire_s1 && step) ? idx_inc : idx_q;
		pend_inc = (&pend_q) ? pend_q : pend_q + 1'b1;
		roll_sum = full_q ? sum_q - SUM_W'(rdata_q) + SUM_W'(byte_s1)
			: sum_q + SUM_W'(byte_s1);
		idx_n  = idx_q;
		full_n = full_q;
		sum_n  = sum_q;
		pend_n = pend_inc;
		sync   = 1'b0;
		cause  = CAUSE_NONE;
		if (info_s1.hdr_end) begin
			idx_n  = '0;
			full_n = 1'b0;
			sum_n  = '0;
			if (pend_inc >= cfg.force_pending
				|| (info_s1.size_ok && pend_inc >= cfg.min_pending)) begin
				pend_n = '0;
				sync   = 1'b1;
				cause  = CAUSE_HEADER;
			end
		end else if (step) begin
			sum_n = roll_sum;
			idx_n = idx_inc;
			if (!full_q) begin
				if (idx_last) begin
					full_n = 1'b1;
				end
			end else if (roll_sum[WIN_AW-1:0] == '0) begin
				idx_n  = '0;
				full_n = 1'b0;
				sum_n  = '0;
				pend_n = '0;
				sync   = 1'b1;
				cause  = CAUSE_ROLL;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && step) begin
			mem[idx_q] <= byte_s1;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			full_q <= 1'b0;
			sum_q  <= '0;
			pend_q <= '0;
		end else if (fire_s1) begin
			idx_q  <= idx_n;
			full_q <= full_n;
			sum_q  <= sum_n;
			pend_q <= pend_n;
		end
	end

endmodule

// ===== rtl/rsyncable_sync_point_detector.sv =====
// Top level of the rsyncable sync point detector: channels, configuration and pipeline control.
`timescale 1ns / 1ps

// The block takes one byte per transfer on the data channel and returns exactly one result
// per byte on the result channel: sync, and sync_cause (none, cpio header end, rolling sum).
// Three threshold registers are written over the cfg channel, which is always ready; they
// should only be written while no byte is in flight.
// A byte is taken in stage one, where the header tracker updates and the window memory is
// read. In the second stage the rolling sum, pending counter and memory write-back are done
// and the result moves into the output register, from which it is offered. One byte per
// cycle is sustained while the receiver takes results: each byte needs one read and one
// write of the window memory, on separate ports, and the next read address never equals
// the entry being written.
// Reset clears all control state and restores the register defaults; the window memory is
// not cleared, as a read entry is only used after it has been written since the last window
// clear. When the receiver stalls, one result waits in the output register and one byte
// in the second stage; data.ready then falls until the receiver takes a result.

module rsyncable_sync_point_detector import rspd_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	rspd_cfg_if.sink    cfg,
	rspd_byte_if.sink   data,
	rspd_res_if.source  result
);

	cfg_t      cfg_q;
	logic      valid_s1;
	logic [7:0] byte_s1;
	hdr_info_t info_s1;
	hdr_info_t info;
	logic      fire_s1;
	logic      accept;
	logic      out_valid_q;
	logic      sync_q;
	cause_e    cause_q;
	logic      sync_c;
	cause_e    cause_c;

	assign cfg.ready  = 1'b1;
	assign fire_s1    = valid_s1 && (!out_valid_q || result.ready);
	assign data.ready = !valid_s1 || fire_s1;
	assign accept     = data.valid && data.ready;

	assign result.valid      = out_valid_q;
	assign result.sync       = sync_q;
	assign result.sync_cause = cause_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.force_pending <= FORCE_PENDING_RST;
			cfg_q.min_file_size <= MIN_FILE_SIZE_RST;
			cfg_q.min_pending   <= MIN_PENDING_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FORCE_PENDING: cfg_q.force_pending <= cfg.data;
				REG_MIN_FILE_SIZE: cfg_q.min_file_size <= cfg.data;
				REG_MIN_PENDING:   cfg_q.min_pending   <= cfg.data;
				default: ;
			endcase
		end
	end

	rspd_hdr u_hdr (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (accept),
		.data_byte (data.data_byte),
		.cfg       (cfg_q),
		.info      (info)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data.ready) begin
			valid_s1 <= data.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data.data_byte;
			info_s1 <= info;
		end
	end

	rspd_win u_win (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.fire_s1 (fire_s1),
		.byte_s1 (byte_s1),
		.info_s1 (info_s1),
		.cfg     (cfg_q),
		.sync    (sync_c),
		.cause   (cause_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			sync_q  <= sync_c;
			cause_q <= cause_c;
		end
	end

`ifndef SYNTHESIS
	a_cause_matches_sync: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.sync == (result.sync_cause != CAUSE_NONE)))
		else $error("sync and sync_cause disagree");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !fire_s1) |=> (valid_s1 && $stable(byte_s1) && $stable(info_s1)))
		else $error("second stage lost or changed a stalled byte");

	a_ready_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		!data.ready |-> (valid_s1 && out_valid_q && !result.ready))
		else $error("input stalled while the pipeline had room");
`endif

endmodule
